// ----- rtl/lpg_pkg.sv -----
// lpg_pkg: shared types and constants of the lissajous point generator
// configuration register map, register file struct and reset values
// no dependencies
package lpg_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_SEL_BITS  = 3;

  // fixed field widths
  localparam int HARM_BITS  = 4;
  localparam int TURN_BITS  = 16;   // phase_offset / phase_step use 65536 per turn
  localparam int GRID_BITS  = 10;
  localparam int COLOR_BITS = 4;
  localparam int SINE_BITS  = 15;   // magnitude of a q1.15 sine sample

  // smallest grid that still gives a centre and an amplitude
  localparam int MIN_GRID = 2;

  typedef enum logic [REG_SEL_BITS-1:0] {
    REG_HARMONIC_X   = 3'd0,
    REG_HARMONIC_Y   = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_GRID_COLUMNS = 3'd3,
    REG_GRID_ROWS    = 3'd4,
    REG_PEN_COLOR    = 3'd5,
    REG_PHASE_STEP   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [HARM_BITS-1:0]  harmonic_x;
    logic [HARM_BITS-1:0]  harmonic_y;
    logic [TURN_BITS-1:0]  phase_offset;
    logic [GRID_BITS-1:0]  grid_columns;
    logic [GRID_BITS-1:0]  grid_rows;
    logic [COLOR_BITS-1:0] pen_color;
    logic [TURN_BITS-1:0]  phase_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    harmonic_x:   4'd1,
    harmonic_y:   4'd1,
    phase_offset: 16'd0,
    grid_columns: 10'd80,
    grid_rows:    10'd24,
    pen_color:    4'd1,
    phase_step:   16'd7
  };

endpackage

// ----- rtl/lissajous_point_generator_core.sv -----
// lissajous_point_generator_core: top level of the lissajous point generator
// apb register file, intake with phase accumulator, queue, coordinate pipeline
// depends on lpg_pkg, lpg_front, lpg_queue, lpg_back
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   input     in_valid / in_ready    advance
//   output    out_valid / out_ready  point_x, point_y, point_color, figure_done
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// one point per clock sustained while the output is not stalled; the phase
// accumulator add is the only item-to-item dependency
// a point passes through the queue, the index stage, the table read stage
// and the scaling into the output register
// reset clears phase, queue and pipeline valids and loads register defaults
// a stalled output backs up the pipeline, then the two-entry queue, then
// in_ready drops; transfers with advance low are taken and produce nothing
module lissajous_point_generator_core #(
  parameter int PHASE_BITS         = 16,
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int COORD_BITS         = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  advance,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [COORD_BITS-1:0]                 point_x,
  output logic [COORD_BITS-1:0]                 point_y,
  output logic [lpg_pkg::COLOR_BITS-1:0]        point_color,
  output logic                                  figure_done,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lpg_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [lpg_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [lpg_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);

  localparam int ENTRY_BITS  = 2 * PHASE_BITS + 1;  // angle_x, angle_y, wrap
  localparam int QUEUE_DEPTH = 2;
  localparam int DW          = lpg_pkg::CFG_DATA_BITS;

  lpg_pkg::cfg_t       cfg;
  lpg_pkg::reg_index_t cfg_sel;
  logic                cfg_write;

  logic                  push;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  logic [ENTRY_BITS-1:0] q_data;

  // register file: word-aligned, one register per 32-bit slot
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = lpg_pkg::reg_index_t'(paddr[lpg_pkg::CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lpg_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        lpg_pkg::REG_HARMONIC_X:   cfg.harmonic_x   <= pwdata[lpg_pkg::HARM_BITS-1:0];
        lpg_pkg::REG_HARMONIC_Y:   cfg.harmonic_y   <= pwdata[lpg_pkg::HARM_BITS-1:0];
        lpg_pkg::REG_PHASE_OFFSET: cfg.phase_offset <= pwdata[lpg_pkg::TURN_BITS-1:0];
        lpg_pkg::REG_GRID_COLUMNS: cfg.grid_columns <= pwdata[lpg_pkg::GRID_BITS-1:0];
        lpg_pkg::REG_GRID_ROWS:    cfg.grid_rows    <= pwdata[lpg_pkg::GRID_BITS-1:0];
        lpg_pkg::REG_PEN_COLOR:    cfg.pen_color    <= pwdata[lpg_pkg::COLOR_BITS-1:0];
        lpg_pkg::REG_PHASE_STEP:   cfg.phase_step   <= pwdata[lpg_pkg::TURN_BITS-1:0];
        default: ;  // unmapped slot, write ignored
      endcase
    end
  end

  // readback, unmapped slots read zero
  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      lpg_pkg::REG_HARMONIC_X:   prdata = DW'(cfg.harmonic_x);
      lpg_pkg::REG_HARMONIC_Y:   prdata = DW'(cfg.harmonic_y);
      lpg_pkg::REG_PHASE_OFFSET: prdata = DW'(cfg.phase_offset);
      lpg_pkg::REG_GRID_COLUMNS: prdata = DW'(cfg.grid_columns);
      lpg_pkg::REG_GRID_ROWS:    prdata = DW'(cfg.grid_rows);
      lpg_pkg::REG_PEN_COLOR:    prdata = DW'(cfg.pen_color);
      lpg_pkg::REG_PHASE_STEP:   prdata = DW'(cfg.phase_step);
      default:                   prdata = '0;
    endcase
  end

  // intake: phase accumulator, angles, wrap detection
  lpg_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .advance   (advance),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples intake from output backpressure
  lpg_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .rd_data   (q_data)
  );

  // sine lookup and scaling to grid coordinates
  lpg_back #(
    .PHASE_BITS         (PHASE_BITS),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .COORD_BITS         (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_color (point_color),
    .figure_done (figure_done)
  );

endmodule

// ----- rtl/lpg_front.sv -----
// lpg_front: phase accumulator and item intake
// turns each advancing transfer into a pair of angles plus the wrap flag
// depends on lpg_pkg
module lpg_front #(
  parameter int PHASE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lpg_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      advance,
  input  logic                      q_full,
  output logic                      push,
  output logic [2*PHASE_BITS:0]     push_data
);

  localparam int UP_SHIFT   = (PHASE_BITS >= lpg_pkg::TURN_BITS) ?
                              PHASE_BITS - lpg_pkg::TURN_BITS : 0;
  localparam int DOWN_SHIFT = (PHASE_BITS < lpg_pkg::TURN_BITS) ?
                              lpg_pkg::TURN_BITS - PHASE_BITS : 0;
  localparam int WIDE_BITS  = PHASE_BITS + lpg_pkg::TURN_BITS;
  localparam int PROD_BITS  = PHASE_BITS + lpg_pkg::HARM_BITS;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [WIDE_BITS-1:0]  offset_wide;
  logic [WIDE_BITS-1:0]  step_wide;
  logic [PHASE_BITS-1:0] offset_scaled;
  logic [PHASE_BITS-1:0] step_scaled;
  logic [PROD_BITS-1:0]  prod_x;
  logic [PROD_BITS-1:0]  prod_y;
  logic [PHASE_BITS-1:0] angle_x;
  logic [PHASE_BITS-1:0] angle_y;
  logic [PHASE_BITS:0]   sum_next;
  logic                  wrap;
  logic                  take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  // a transfer with advance low is consumed and dropped
  assign push     = take && advance;

  // 65536-per-turn registers rescaled to the accumulator width
  assign offset_wide   = (WIDE_BITS'(cfg.phase_offset) << UP_SHIFT) >> DOWN_SHIFT;
  assign step_wide     = (WIDE_BITS'(cfg.phase_step) << UP_SHIFT) >> DOWN_SHIFT;
  assign offset_scaled = offset_wide[PHASE_BITS-1:0];
  assign step_scaled   = step_wide[PHASE_BITS-1:0];

  assign prod_x  = PROD_BITS'(cfg.harmonic_x) * PROD_BITS'(phase);
  assign prod_y  = PROD_BITS'(cfg.harmonic_y) * PROD_BITS'(phase);
  assign angle_x = prod_x[PHASE_BITS-1:0] + offset_scaled;
  assign angle_y = prod_y[PHASE_BITS-1:0];

  assign sum_next   = {1'b0, phase} + {1'b0, step_scaled};
  assign wrap       = sum_next[PHASE_BITS];
  assign phase_next = wrap ? '0 : sum_next[PHASE_BITS-1:0];

  assign push_data = {angle_x, angle_y, wrap};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase_next;
    end
  end

  a_idle_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (take && !advance) |=> $stable(phase))
    else $error("phase moved on a non-advancing transfer");

  a_wrap_restarts: assert property (@(posedge clk) disable iff (rst)
    (push && wrap) |=> (phase == '0))
    else $error("phase did not restart after a wrap");

endmodule

// ----- rtl/lpg_queue.sv -----
// lpg_queue: short fifo between intake and coordinate pipeline
// register slots, one write and one read per cycle
// no dependencies
module lpg_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/lpg_back.sv -----
// lpg_back: coordinate pipeline, angle to table index, sine lookup, scaling
// three register stages with per-stage stall, output register last
// depends on lpg_pkg
module lpg_back #(
  parameter int PHASE_BITS         = 16,
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int COORD_BITS         = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lpg_pkg::cfg_t                      cfg,
  input  logic                               q_valid,
  input  logic [2*PHASE_BITS:0]              q_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_BITS-1:0]              point_x,
  output logic [COORD_BITS-1:0]              point_y,
  output logic [lpg_pkg::COLOR_BITS-1:0]     point_color,
  output logic                               figure_done
);

  localparam int QUARTER_BITS = PHASE_BITS - 2;
  localparam int IDX_BITS     = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int BASE_BITS    = QUARTER_BITS + 1;
  localparam int SCALE_BITS   = BASE_BITS + IDX_BITS;
  localparam int SB           = lpg_pkg::SINE_BITS;
  localparam int GB           = lpg_pkg::GRID_BITS;
  localparam int AMP_PROD     = GB + SB - 1;

  // quarter-wave table, built at elaboration with a q2.30 taylor series
  localparam int     TAYLOR_TERMS = 9;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint ROUND_Q15    = 64'sd16384;
  localparam longint Q15_SCALE    = 64'sd32768;
  localparam longint SINE_MAX     = 64'sd32767;
  localparam longint TAYLOR_DIV [1:TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef logic [SB-1:0] rom_t [SINE_TABLE_ENTRIES+1];

  function automatic rom_t build_rom();
    rom_t   rom;
    longint x;
    longint term;
    longint sum;
    longint r;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      term = x;
      sum  = x;
      for (int i = 1; i <= TAYLOR_TERMS; i++) begin
        term = (term * x) / ONE_Q30;
        term = (term * x) / ONE_Q30;
        term = -(term / TAYLOR_DIV[i]);
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      r = (sum + ROUND_Q15) / Q15_SCALE;
      if (r > SINE_MAX) r = SINE_MAX;
      rom[k] = SB'(r);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // angle within its quadrant to a table index, mirrored on odd quadrants
  function automatic logic [IDX_BITS-1:0] table_index(input logic [PHASE_BITS-1:0] angle);
    logic [BASE_BITS-1:0]  base;
    logic [SCALE_BITS-1:0] scaled;
    logic [IDX_BITS:0]     idx;
    if (angle[QUARTER_BITS]) begin
      base = {1'b1, {QUARTER_BITS{1'b0}}} - {1'b0, angle[QUARTER_BITS-1:0]};
    end else begin
      base = {1'b0, angle[QUARTER_BITS-1:0]};
    end
    scaled = SCALE_BITS'(base) * SCALE_BITS'(SINE_TABLE_ENTRIES);
    idx    = scaled[SCALE_BITS-1:QUARTER_BITS];
    if (idx > (IDX_BITS+1)'(SINE_TABLE_ENTRIES)) begin
      idx = (IDX_BITS+1)'(SINE_TABLE_ENTRIES);
    end
    return idx[IDX_BITS-1:0];
  endfunction

  // centre plus or minus amplitude times sine, truncated toward zero
  function automatic logic [COORD_BITS-1:0] place(input logic [GB-1:0] cells,
                                                  input logic [SB-1:0] s,
                                                  input logic          neg);
    logic [GB-1:0]       n;
    logic [GB-2:0]       mid;
    logic [GB-2:0]       amp;
    logic [AMP_PROD-1:0] prod;
    logic [GB-2:0]       mag;
    logic [GB:0]         v;
    n    = (cells < GB'(lpg_pkg::MIN_GRID)) ? GB'(lpg_pkg::MIN_GRID) : cells;
    mid  = n[GB-1:1];
    amp  = mid - (GB-1)'(1);
    prod = AMP_PROD'(amp) * AMP_PROD'(s);
    mag  = prod[AMP_PROD-1:SB];
    v    = neg ? ({2'b00, mid} - {2'b00, mag}) : ({2'b00, mid} + {2'b00, mag});
    return COORD_BITS'(v);
  endfunction

  logic [PHASE_BITS-1:0] q_angle_x;
  logic [PHASE_BITS-1:0] q_angle_y;
  logic                  q_done;

  logic                  rdy1;
  logic                  rdy2;
  logic                  rdy3;

  logic                  v1;
  logic [IDX_BITS-1:0]   idx_x1;
  logic [IDX_BITS-1:0]   idx_y1;
  logic                  neg_x1;
  logic                  neg_y1;
  logic                  done1;

  logic                  v2;
  logic [SB-1:0]         sin_x2;
  logic [SB-1:0]         sin_y2;
  logic                  neg_x2;
  logic                  neg_y2;
  logic                  done2;

  assign q_angle_x = q_data[2*PHASE_BITS:PHASE_BITS+1];
  assign q_angle_y = q_data[PHASE_BITS:1];
  assign q_done    = q_data[0];

  assign rdy3 = !out_valid || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pop  = q_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= q_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      idx_x1 <= table_index(q_angle_x);
      idx_y1 <= table_index(q_angle_y);
      neg_x1 <= q_angle_x[PHASE_BITS-1];
      neg_y1 <= q_angle_y[PHASE_BITS-1];
      done1  <= q_done;
    end
    if (rdy2) begin
      sin_x2 <= SINE_ROM[idx_x1];
      sin_y2 <= SINE_ROM[idx_y1];
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      done2  <= done1;
    end
    if (rdy3) begin
      point_x     <= place(cfg.grid_columns, sin_x2, neg_x2);
      point_y     <= place(cfg.grid_rows, sin_y2, neg_y2);
      point_color <= cfg.pen_color;
      figure_done <= done2;
    end
  end

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("popped entry did not reach the index stage");

endmodule

// ----- dv/testbench.sv -----
// testbench: self-checking bench for lissajous_point_generator_core
// drives ticks in bursts, stalls the point output, rewrites the registers over apb
// depends on lpg_pkg and the rtl of the core
module testbench;

  // predictor geometry, same as the core defaults
  localparam int     PHASE_W       = 16;    // equal to the 16-bit turn, so no rescale
  localparam int     QUARTER_BITS  = PHASE_W - 2;
  localparam int     SINE_ENTRIES  = 1024;
  localparam int     COORD_W       = 10;
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint ONE_Q30       = 64'sd1073741824;

  // run control
  localparam int SETTLE_CYCLES = 8;       // pipeline latency plus margin
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_PHASES = 12;
  localparam int TICKS_PER_PHASE = 100;

  // decodes to no register at all
  localparam logic [lpg_pkg::REG_SEL_BITS-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0]             x;
    logic [COORD_W-1:0]             y;
    logic [lpg_pkg::COLOR_BITS-1:0] color;
    logic                           done;
  } point_t;

  typedef enum logic {
    ROW_CONFIG,
    ROW_TICK
  } row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [lpg_pkg::REG_SEL_BITS-1:0] reg_idx;
    logic [31:0]                      reg_value;
    logic                             adv;
    bit                               typed;
    point_t                           want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY
  } stall_mode_t;

  // dut signals; the inputs are known from time zero
  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              advance = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [COORD_W-1:0]                point_x;
  logic [COORD_W-1:0]                point_y;
  logic [lpg_pkg::COLOR_BITS-1:0]    point_color;
  logic                              figure_done;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [lpg_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [lpg_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
  logic [lpg_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  // predictor state: its own register copy, phase and sine table
  lpg_pkg::cfg_t            model_cfg = lpg_pkg::CFG_RESET;
  logic [PHASE_W-1:0]       phase_acc = '0;
  int                       sine_quarter [0:SINE_ENTRIES];

  // points predicted and not yet seen at the output
  point_t                   pending_points [$];
  stim_row_t                directed_rows [$];

  int                       failures = 0;
  int                       points_checked = 0;
  int                       wraps_seen = 0;
  int                       idle_ticks = 0;
  int                       settings_used = 0;
  int                       burst_left = 0;
  int                       cycle_count = 0;
  stall_mode_t              stall_mode = STALL_NONE;
  int                       stall_left = 0;

  lissajous_point_generator_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_color (point_color),
    .figure_done (figure_done),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave sine, q1.15, from a q2.30 taylor series up to x^19
  initial begin : sine_fill
    longint xq, term, acc, r;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      xq = (longint'(k) * HALF_PI_Q30) / SINE_ENTRIES;
      term = xq;
      acc = xq;
      for (int i = 1; i <= 9; i++) begin
        term = (term * xq) / ONE_Q30;
        term = (term * xq) / ONE_Q30;
        term = -(term / longint'((2 * i) * (2 * i + 1)));
        acc += term;
      end
      if (acc < 0) acc = 0;
      r = (acc + 16384) / 32768;
      if (r > 32767) r = 32767;
      sine_quarter[k] = int'(r);
    end
  end

  // one axis: centre plus amplitude times sine, product truncated toward zero
  function automatic logic [COORD_W-1:0] grid_coord(
      input logic [lpg_pkg::GRID_BITS-1:0] cells,
      input logic [PHASE_W-1:0]            angle);
    int n, mid, amp, idx, s, mag;
    logic [1:0] quad;
    int pos;
    n = (cells < lpg_pkg::MIN_GRID) ? lpg_pkg::MIN_GRID : int'(cells);
    mid = n / 2;
    amp = mid - 1;
    quad = angle[PHASE_W-1 -: 2];
    pos = int'(angle[QUARTER_BITS-1:0]);
    // odd quadrants read the table backward, the lower half is negated
    if (quad[0]) idx = (((1 << QUARTER_BITS) - pos) * SINE_ENTRIES) >> QUARTER_BITS;
    else idx = (pos * SINE_ENTRIES) >> QUARTER_BITS;
    if (idx > SINE_ENTRIES) idx = SINE_ENTRIES;
    s = sine_quarter[idx];
    mag = (amp * s) >> lpg_pkg::SINE_BITS;
    return COORD_W'(quad[1] ? mid - mag : mid + mag);
  endfunction

  // directed table builders
  function automatic void add_config(input logic [lpg_pkg::REG_SEL_BITS-1:0] idx,
                                     input logic [31:0] value);
    stim_row_t row;
    row = '{kind: ROW_CONFIG, reg_idx: idx, reg_value: value, adv: 1'b0,
            typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_tick(input logic adv);
    stim_row_t row;
    row = '{kind: ROW_TICK, reg_idx: '0, reg_value: '0, adv: adv,
            typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(input int x, input int y, input int color, input bit done);
    stim_row_t row;
    row = '{kind: ROW_TICK, reg_idx: '0, reg_value: '0, adv: 1'b1, typed: 1'b1,
            want: '{x: COORD_W'(x), y: COORD_W'(y),
                    color: lpg_pkg::COLOR_BITS'(color), done: done}};
    directed_rows.push_back(row);
  endfunction

  // one tick transfer; the sender works in bursts with random gaps between them
  task automatic send_tick(input logic adv, input bit typed, input point_t typed_point);
    int gap;
    logic [31:0] ang_x, ang_y;
    logic [PHASE_W:0] next_phase;
    point_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    advance <= adv;
    do @(posedge clk); while (!in_ready);
    // transfer happened at this edge
    if (adv) begin
      ang_x = 32'(model_cfg.harmonic_x) * 32'(phase_acc) + 32'(model_cfg.phase_offset);
      ang_y = 32'(model_cfg.harmonic_y) * 32'(phase_acc);
      p.x = grid_coord(model_cfg.grid_columns, ang_x[PHASE_W-1:0]);
      p.y = grid_coord(model_cfg.grid_rows, ang_y[PHASE_W-1:0]);
      p.color = model_cfg.pen_color;
      // a carry out of the add ends the figure and restarts at phase zero
      next_phase = {1'b0, phase_acc} + {1'b0, model_cfg.phase_step};
      p.done = next_phase[PHASE_W];
      phase_acc = p.done ? '0 : next_phase[PHASE_W-1:0];
      pending_points.push_back(typed ? typed_point : p);
    end else begin
      idle_ticks++;
    end
  endtask

  // register write while the core is idle: setup cycle, then access cycle
  task automatic write_reg(input logic [lpg_pkg::REG_SEL_BITS-1:0] idx,
                           input logic [31:0] value);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    // idle ticks may still be in flight without any expectation
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lpg_pkg::REG_HARMONIC_X:
        model_cfg.harmonic_x   = value[lpg_pkg::HARM_BITS-1:0];
      lpg_pkg::REG_HARMONIC_Y:
        model_cfg.harmonic_y   = value[lpg_pkg::HARM_BITS-1:0];
      lpg_pkg::REG_PHASE_OFFSET:
        model_cfg.phase_offset = value[lpg_pkg::TURN_BITS-1:0];
      lpg_pkg::REG_GRID_COLUMNS:
        model_cfg.grid_columns = value[lpg_pkg::GRID_BITS-1:0];
      lpg_pkg::REG_GRID_ROWS:
        model_cfg.grid_rows    = value[lpg_pkg::GRID_BITS-1:0];
      lpg_pkg::REG_PEN_COLOR:
        model_cfg.pen_color    = value[lpg_pkg::COLOR_BITS-1:0];
      lpg_pkg::REG_PHASE_STEP:
        model_cfg.phase_step   = value[lpg_pkg::TURN_BITS-1:0];
      default: ;
    endcase
    settings_used++;
  endtask

  // receiver stall pattern: free running, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_ready <= 1'b1;
      STALL_COIN: out_ready <= 1'($urandom_range(0, 1));
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // point checker: every output transfer against the oldest prediction
  always @(posedge clk) begin : point_check
    point_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{x: point_x, y: point_y, color: point_color, done: figure_done};
      if (pending_points.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected point x=%0d y=%0d color=%0d done=%0d",
                   got.x, got.y, got.color, got.done);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
            got.done !== want.done) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display({"point %0d mismatch: expected x=%0d y=%0d color=%0d done=%0d,",
                      " got x=%0d y=%0d color=%0d done=%0d"},
                     points_checked, want.x, want.y, want.color, want.done,
                     got.x, got.y, got.color, got.done);
        end
        if (want.done) wraps_seen++;
        points_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding",
               cycle_count, pending_points.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int ticks;
    logic [15:0] step_val;
    int pick;

    // directed table; known values come from phase zero and quarter-turn angles
    add_known(40, 12, 1, 1'b0);                  // first point after reset
    add_tick(1'b0);                              // idle tick, no point
    add_config(lpg_pkg::REG_PHASE_STEP, 32'd65535);
    add_known(40, 12, 1, 1'b1);                  // phase 7 plus a full step wraps
    add_known(40, 12, 1, 1'b0);                  // restart at phase zero
    add_tick(1'b1);                              // top of the accumulator, wraps again
    add_config(lpg_pkg::REG_PHASE_STEP, 32'd0);  // zero step holds the phase
    add_known(40, 12, 1, 1'b0);
    add_known(40, 12, 1, 1'b0);
    add_tick(1'b0);
    add_config(lpg_pkg::REG_GRID_COLUMNS, 32'd0);  // grids below two act as two
    add_config(lpg_pkg::REG_GRID_ROWS, 32'd1);
    add_config(lpg_pkg::REG_PEN_COLOR, 32'd15);
    add_known(1, 1, 15, 1'b0);
    add_config(lpg_pkg::REG_GRID_COLUMNS, 32'd1023);
    add_config(lpg_pkg::REG_GRID_ROWS, 32'd1023);
    add_known(511, 511, 15, 1'b0);
    add_config(lpg_pkg::REG_PHASE_OFFSET, 32'd16384);  // sine peak, capped table entry
    add_known(1020, 511, 15, 1'b0);
    add_config(lpg_pkg::REG_PHASE_OFFSET, 32'd49152);  // negative peak
    add_known(2, 511, 15, 1'b0);
    // harmonic zero freezes x, high harmonics wrap the angle
    add_config(lpg_pkg::REG_HARMONIC_X, 32'd0);
    add_config(lpg_pkg::REG_HARMONIC_Y, 32'd15);
    add_config(lpg_pkg::REG_PHASE_STEP, 32'd1);
    add_config(lpg_pkg::REG_PHASE_OFFSET, 32'd0);
    repeat (4) add_tick(1'b1);
    add_config(lpg_pkg::REG_HARMONIC_X, 32'd15);
    add_config(lpg_pkg::REG_HARMONIC_Y, 32'd11);
    add_config(lpg_pkg::REG_PHASE_STEP, 32'd12000);
    add_config(lpg_pkg::REG_PHASE_OFFSET, 32'd65535);
    repeat (6) add_tick(1'b1);
    add_config(REG_UNMAPPED, 32'hffff_ffff);    // write to no register
    repeat (2) add_tick(1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      else
        send_tick(directed_rows[i].adv, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases: a fresh setting, then a run of ticks with some idle ones
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        // low extremes
        write_reg(lpg_pkg::REG_HARMONIC_X, 32'd1);
        write_reg(lpg_pkg::REG_HARMONIC_Y, 32'd1);
        write_reg(lpg_pkg::REG_PHASE_OFFSET, 32'd0);
        write_reg(lpg_pkg::REG_GRID_COLUMNS, 32'd2);
        write_reg(lpg_pkg::REG_GRID_ROWS, 32'd2);
        write_reg(lpg_pkg::REG_PEN_COLOR, 32'd1);
        write_reg(lpg_pkg::REG_PHASE_STEP, 32'd1);
      end else if (ph == 1) begin
        // high extremes, harmonics at ten of a possible fifteen
        write_reg(lpg_pkg::REG_HARMONIC_X, 32'd10);
        write_reg(lpg_pkg::REG_HARMONIC_Y, 32'd10);
        write_reg(lpg_pkg::REG_PHASE_OFFSET, 32'd65535);
        write_reg(lpg_pkg::REG_GRID_COLUMNS, 32'd1023);
        write_reg(lpg_pkg::REG_GRID_ROWS, 32'd1023);
        write_reg(lpg_pkg::REG_PEN_COLOR, 32'd15);
        write_reg(lpg_pkg::REG_PHASE_STEP, 32'd65535);
      end else begin
        pick = $urandom_range(0, 11);
        if (pick == 0) step_val = 16'd0;
        else if (pick <= 3) step_val = 16'($urandom_range(1, 64));
        else if (pick <= 7) step_val = 16'($urandom_range(65, 4096));
        else step_val = 16'($urandom_range(4097, 65535));
        write_reg(lpg_pkg::REG_HARMONIC_X,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 10));
        write_reg(lpg_pkg::REG_HARMONIC_Y,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 10));
        write_reg(lpg_pkg::REG_PHASE_OFFSET, $urandom_range(0, 65535));
        write_reg(lpg_pkg::REG_GRID_COLUMNS,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(2, 200));
        write_reg(lpg_pkg::REG_GRID_ROWS,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(2, 200));
        write_reg(lpg_pkg::REG_PEN_COLOR, $urandom_range(0, 15));
        write_reg(lpg_pkg::REG_PHASE_STEP, 32'(step_val));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, $urandom);
      end
      // every transfer counts, idle or advancing
      ticks = 0;
      while (ticks < TICKS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          send_tick(1'b1, 1'b0, '0);
        end else begin
          send_tick(1'b0, 1'b0, '0);
        end
        ticks++;
      end
    end

    // drain: every prediction must come out, then watch for strays
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += pending_points.size();

    $display("checked %0d points (%0d figure wraps) and %0d idle ticks",
             points_checked, wraps_seen, idle_ticks);
    $display("over %0d register writes, %0d failures in %0d cycles",
             settings_used, failures, cycle_count);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lpg_pkg.sv
rtl/lpg_front.sv
rtl/lpg_queue.sv
rtl/lpg_back.sv
rtl/lissajous_point_generator_core.sv
dv/testbench.sv
